// ----- design/m4mul_pkg.sv -----
// ============================================================================
// m4mul_pkg
// Shared types and field widths for the matrix multiply core.
// ============================================================================
package m4mul_pkg;

    localparam int IDX_W   = 4;
    localparam int VAL_W   = 32;
    localparam int TDATA_W = 40;

    typedef struct packed {
        logic rd_en;
        logic first;
        logic lastk;
    } m4mul_cmd_t;

    typedef struct packed {
        logic res_done;
        logic out_busy;
    } m4mul_stat_t;

endpackage

// ----- design/m4mul_ctrl.sv -----
// ============================================================================
// m4mul_ctrl
// Sequencer: columns, rows, inner-product index; one read a cycle in S_ISSUE.
// ============================================================================
module m4mul_ctrl
    import m4mul_pkg::*;
#(
    parameter int MATRIX_DIM = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_accept,
    input  logic                          in_go,
    output logic                          in_ready,
    output m4mul_cmd_t                    cmd,
    output logic [$clog2(MATRIX_DIM)-1:0] col,
    output logic [$clog2(MATRIX_DIM)-1:0] row,
    output logic [$clog2(MATRIX_DIM)-1:0] k,
    input  m4mul_stat_t                   stat
);

    localparam int CW = $clog2(MATRIX_DIM);
    localparam logic [CW-1:0] LAST_IDX = CW'(MATRIX_DIM - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_ISSUE,
        S_DRAIN
    } state_t;

    state_t        state_reg;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] row_reg;
    logic [CW-1:0] k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept && in_go)
                    begin
                        col_reg   <= '0;
                        row_reg   <= '0;
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (!stat.out_busy)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE:
                begin
                    if (k_reg == LAST_IDX)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    if (stat.res_done)
                    begin
                        if ((col_reg == LAST_IDX) && (row_reg == LAST_IDX))
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            if (row_reg == LAST_IDX)
                            begin
                                row_reg <= '0;
                                col_reg <= col_reg + 1'b1;
                            end
                            else
                            begin
                                row_reg <= row_reg + 1'b1;
                            end
                            state_reg <= S_WAIT;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cmd.rd_en = (state_reg == S_ISSUE);
    assign cmd.first = (k_reg == '0);
    assign cmd.lastk = (k_reg == LAST_IDX);
    assign col       = col_reg;
    assign row       = row_reg;
    assign k         = k_reg;

    a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        stat.res_done |-> (state_reg == S_DRAIN))
        else $error("result completed outside drain");

    a_issue_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ISSUE) |-> !stat.out_busy)
        else $error("issuing while output register occupied");

endmodule

// ----- design/m4mul_datapath.sv -----
// ============================================================================
// m4mul_datapath
// Operand stores, registered multiply, wide accumulator, shift and saturate.
// ============================================================================
module m4mul_datapath
    import m4mul_pkg::*;
#(
    parameter int MATRIX_DIM    = 4,
    parameter int FRACTION_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic                          wr_which,
    input  logic [IDX_W-1:0]              wr_idx,
    input  logic [VAL_W-1:0]              wr_value,
    input  m4mul_cmd_t                    cmd,
    input  logic [$clog2(MATRIX_DIM)-1:0] col,
    input  logic [$clog2(MATRIX_DIM)-1:0] row,
    input  logic [$clog2(MATRIX_DIM)-1:0] k,
    output m4mul_stat_t                   stat,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [IDX_W-1:0]              out_index,
    output logic [VAL_W-1:0]              out_value,
    output logic                          out_sat,
    output logic                          out_last
);

    localparam int ELEMS = MATRIX_DIM * MATRIX_DIM;
    localparam int AW    = $clog2(ELEMS);
    localparam int CW    = $clog2(MATRIX_DIM);
    localparam int ACC_W = 2 * VAL_W + $clog2(MATRIX_DIM);
    localparam int TOP_L = VAL_W - 1 + FRACTION_BITS;
    localparam logic [AW-1:0] DIM_A    = AW'(MATRIX_DIM);
    localparam logic [CW-1:0] LAST_IDX = CW'(MATRIX_DIM - 1);

    logic [VAL_W-1:0] l_mem [ELEMS];
    logic [VAL_W-1:0] r_mem [ELEMS];
    logic [ELEMS-1:0] l_vld_reg;
    logic [ELEMS-1:0] r_vld_reg;

    logic [AW-1:0] wr_addr;
    logic          wr_in_range;
    logic [AW-1:0] l_addr;
    logic [AW-1:0] r_addr;

    logic signed [VAL_W-1:0]   l_rd_reg;
    logic signed [VAL_W-1:0]   r_rd_reg;
    logic signed [2*VAL_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_base;
    logic                      s1_vld_reg;
    logic                      s1_first_reg;
    logic                      s1_lastk_reg;
    logic                      s2_vld_reg;
    logic                      s2_first_reg;
    logic                      s2_lastk_reg;
    logic                      fin_reg;

    logic [ACC_W-1-TOP_L:0] top_bits;
    logic                   in_range;

    logic                   out_vld_reg;
    logic [IDX_W-1:0]       out_index_reg;
    logic [VAL_W-1:0]       out_value_reg;
    logic                   out_sat_reg;
    logic                   out_last_reg;

    assign wr_in_range = ({{(32-IDX_W){1'b0}}, wr_idx} < 32'(ELEMS));
    assign wr_addr     = AW'(wr_idx);
    assign l_addr      = AW'(AW'(k) * DIM_A + AW'(row));
    assign r_addr      = AW'(AW'(col) * DIM_A + AW'(k));

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_in_range && !wr_which)
        begin
            l_mem[wr_addr] <= wr_value;
        end
        if (wr_en && wr_in_range && wr_which)
        begin
            r_mem[wr_addr] <= wr_value;
        end
        l_rd_reg <= l_vld_reg[l_addr] ? l_mem[l_addr] : '0;
        r_rd_reg <= r_vld_reg[r_addr] ? r_mem[r_addr] : '0;
        prod_reg <= l_rd_reg * r_rd_reg;
        if (s2_vld_reg)
        begin
            acc_reg <= acc_base + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_vld_reg <= '0;
            r_vld_reg <= '0;
        end
        else if (wr_en && wr_in_range)
        begin
            if (wr_which)
            begin
                r_vld_reg[wr_addr] <= 1'b1;
            end
            else
            begin
                l_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg   <= 1'b0;
            s1_first_reg <= 1'b0;
            s1_lastk_reg <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s2_first_reg <= 1'b0;
            s2_lastk_reg <= 1'b0;
            fin_reg      <= 1'b0;
        end
        else
        begin
            s1_vld_reg   <= cmd.rd_en;
            s1_first_reg <= cmd.first;
            s1_lastk_reg <= cmd.lastk;
            s2_vld_reg   <= s1_vld_reg;
            s2_first_reg <= s1_first_reg;
            s2_lastk_reg <= s1_lastk_reg;
            fin_reg      <= s2_vld_reg && s2_lastk_reg;
        end
    end

    assign acc_base = s2_first_reg ? '0 : acc_reg;
    assign top_bits = acc_reg[ACC_W-1:TOP_L];
    assign in_range = (&top_bits) || !(|top_bits);

    always_ff @(posedge clk)
    begin
        if (fin_reg)
        begin
            out_index_reg <= IDX_W'(AW'(col) * DIM_A + AW'(row));
            out_last_reg  <= (col == LAST_IDX) && (row == LAST_IDX);
            out_sat_reg   <= !in_range;
            if (in_range)
            begin
                out_value_reg <= acc_reg[TOP_L:FRACTION_BITS];
            end
            else if (acc_reg[ACC_W-1])
            begin
                out_value_reg <= {1'b1, {(VAL_W-1){1'b0}}};
            end
            else
            begin
                out_value_reg <= {1'b0, {(VAL_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (fin_reg)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    assign stat.res_done = fin_reg;
    assign stat.out_busy = out_vld_reg;
    assign out_valid     = out_vld_reg;
    assign out_index     = out_index_reg;
    assign out_value     = out_value_reg;
    assign out_sat       = out_sat_reg;
    assign out_last      = out_last_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> !out_vld_reg)
        else $error("result written over a pending beat");

endmodule

// ----- design/mat4_multiply_core.sv -----
// ============================================================================
// mat4_multiply_core
// Fixed-point square matrix product, left times right, column-major.
// ============================================================================
// Input stream: each beat writes one element of the left (tuser = 0) or
// right (tuser = 1) matrix at the index in tdata. A beat with tlast set
// stores its element and then starts the product. Out-of-range indices
// are not stored.
// Output stream: one beat per product element in column-major order;
// tuser flags saturation and tlast marks the final element.
// Each element waits for the output register to be free, then issues
// one read pair per inner-product step from the operand stores, then
// passes through the multiply, accumulate and shift/saturate
// registers. tready on the input is low from the start beat until the
// last element has been loaded into the output register.
// Reset clears both matrices to zero and drops any pending output.
// When the receiver stalls, the finished element holds in the output
// register and the next element is not started until it is taken.
// ============================================================================
module mat4_multiply_core
    import m4mul_pkg::*;
#(
    parameter int MATRIX_DIM    = 4,
    parameter int FRACTION_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,  // element_index[3:0], element_value[35:4]
    input  logic               s_axis_tuser,  // which_matrix
    input  logic               s_axis_tlast,  // go
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,  // result_index[3:0], result_value[35:4]
    output logic               m_axis_tuser,  // saturated
    output logic               m_axis_tlast   // last
);

    localparam int CW = $clog2(MATRIX_DIM);

    m4mul_cmd_t       cmd;
    m4mul_stat_t      stat;
    logic [CW-1:0]    col;
    logic [CW-1:0]    row;
    logic [CW-1:0]    k;
    logic             in_accept;
    logic [IDX_W-1:0] res_index;
    logic [VAL_W-1:0] res_value;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    m4mul_ctrl #(
        .MATRIX_DIM (MATRIX_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_go     (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .cmd       (cmd),
        .col       (col),
        .row       (row),
        .k         (k),
        .stat      (stat)
    );

    m4mul_datapath #(
        .MATRIX_DIM    (MATRIX_DIM),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (in_accept),
        .wr_which  (s_axis_tuser),
        .wr_idx    (s_axis_tdata[IDX_W-1:0]),
        .wr_value  (s_axis_tdata[IDX_W+VAL_W-1:IDX_W]),
        .cmd       (cmd),
        .col       (col),
        .row       (row),
        .k         (k),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_index (res_index),
        .out_value (res_value),
        .out_sat   (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {{(TDATA_W-IDX_W-VAL_W){1'b0}}, res_value, res_index};

endmodule
